/* hw/rtl/assert_macros.svh */
// Assertion helpers. Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mwvq_pkg.sv */
package mwvq_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int WSQ_W       = WEIGHT_BITS + SQ_W;
    localparam int CMD_BITS    = 2;
    localparam int ADDR_BITS   = 15;
    localparam int INDEX_BITS  = 10;
    localparam int ERROR_BITS  = 37;
    localparam int VDIM_BITS   = 6;
    localparam int ECNT_BITS   = 11;
    localparam int CFG_BITS    = 11;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CMD_BITS-1:0] CMD_WRITE_CODE   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE_TARGET = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH       = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_VECTOR_DIM  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_COUNT = 1'b1;

    localparam logic [VDIM_BITS-1:0] VECTOR_DIM_RESET  = 6'd20;
    localparam logic [ECNT_BITS-1:0] ENTRY_COUNT_RESET = 11'd1024;

    localparam logic [ERROR_BITS-1:0] ERR_MAX = '1;

    typedef struct packed {
        logic [CMD_BITS-1:0]           cmd;
        logic [ADDR_BITS-1:0]          addr;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [WEIGHT_BITS-1:0]        weight;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] best_index;
        logic [ERROR_BITS-1:0] min_error;
    } out_word_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } elem_ctl_t;

endpackage

/* hw/rtl/masked_weighted_vq_search.sv */
// Weighted nearest-neighbor search over a codebook held in on-chip memory. Load words
// (codebook word, target element and weight) are taken one per cycle while no search
// is in progress. A search word reads one codebook word per cycle through the single
// read port of the codebook memory; the input is ready again in the same cycle in which
// its result word becomes valid. With either register at zero the scan is skipped and
// the search goes straight to the result state. The result waits in an output register
// while load words keep flowing. The memories are not cleared: codebook words and target
// elements must be written before a search reads them.
`include "assert_macros.svh"

module masked_weighted_vq_search #(
    parameter int DIM_MAX     = 32,
    parameter int ENTRIES_MAX = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  mwvq_pkg::in_word_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output mwvq_pkg::out_word_t                    out_data,
    input  logic                                   cfg_we,
    input  logic [mwvq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [mwvq_pkg::CFG_BITS-1:0]          cfg_data
);
    import mwvq_pkg::*;

    localparam int STORE_DEPTH = DIM_MAX * ENTRIES_MAX;
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int XW    = ((AW > ADDR_BITS) ? AW : ADDR_BITS) + 1;
    localparam int DIW   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DW    = ($clog2(DIM_MAX + 1) > VDIM_BITS) ? $clog2(DIM_MAX + 1) : VDIM_BITS;
    localparam int CNT_W = ($clog2(ENTRIES_MAX + 1) > ECNT_BITS) ?
                           $clog2(ENTRIES_MAX + 1) : ECNT_BITS;
    localparam int ERR_W = SQ_W + $clog2(DIM_MAX);
    localparam int MET_W = WSQ_W + $clog2(DIM_MAX);
    localparam int EXT_W = (ERR_W > ERROR_BITS) ? ERR_W : ERROR_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VDIM_BITS-1:0]   dim_cfg_reg, dim_cfg_next;
    logic [ECNT_BITS-1:0]   cnt_cfg_reg, cnt_cfg_next;
    logic [DIW-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    elem_ctl_t              issue_ctl_reg, issue_ctl_next;
    logic [CNT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [MET_W-1:0]       min_metric_reg, min_metric_next;
    logic [EXT_W-1:0]       best_err_reg, best_err_next;
    logic [INDEX_BITS-1:0]  best_idx_reg, best_idx_next;
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_data_reg, out_data_next;

    logic [SAMPLE_BITS-1:0]                 cb_mem [STORE_DEPTH];
    logic [SAMPLE_BITS+WEIGHT_BITS-1:0]     tgt_mem [DIM_MAX];
    logic [SAMPLE_BITS-1:0]                 cb_rdata_reg;
    logic [SAMPLE_BITS+WEIGHT_BITS-1:0]     tgt_rdata_reg;

    logic             in_fire;
    logic [DW-1:0]    dim_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic             last_dim;
    logic             last_entry;
    logic             last_cmp;
    logic             take;
    logic             entry_done;
    logic [ERR_W-1:0] entry_err;
    logic [MET_W-1:0] entry_metric;
    logic [ERROR_BITS-1:0] err_sat;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign dim_eff = (DW'(dim_cfg_reg) > DW'(DIM_MAX)) ? DW'(DIM_MAX) : DW'(dim_cfg_reg);
    assign cnt_eff = (CNT_W'(cnt_cfg_reg) > CNT_W'(ENTRIES_MAX)) ?
                     CNT_W'(ENTRIES_MAX) : CNT_W'(cnt_cfg_reg);

    assign last_dim   = (DW'(i_reg) == dim_eff - DW'(1));
    assign last_entry = (j_reg == cnt_eff - CNT_W'(1));
    assign last_cmp   = (cmp_idx_reg == cnt_eff - CNT_W'(1));
    assign take       = entry_done && ((cmp_idx_reg == '0) || (entry_metric < min_metric_reg));
    assign err_sat    = (best_err_reg > EXT_W'(ERR_MAX)) ? ERR_MAX
                                                          : best_err_reg[ERROR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            unique case (in_data.cmd)
                CMD_WRITE_CODE:
                begin
                    if (XW'(in_data.addr) < XW'(STORE_DEPTH))
                    begin
                        cb_mem[AW'(in_data.addr)] <= in_data.value;
                    end
                end
                CMD_WRITE_TARGET:
                begin
                    if (XW'(in_data.addr) < XW'(DIM_MAX))
                    begin
                        tgt_mem[DIW'(in_data.addr)] <= {in_data.value, in_data.weight};
                    end
                end
                default:
                begin
                end
            endcase
        end
        cb_rdata_reg  <= cb_mem[rd_addr_reg];
        tgt_rdata_reg <= tgt_mem[i_reg];
    end

    mwvq_dist #(
        .DIM_MAX (DIM_MAX)
    ) u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (issue_ctl_reg),
        .cb_word      (cb_rdata_reg),
        .tgt_value    (tgt_rdata_reg[SAMPLE_BITS+WEIGHT_BITS-1:WEIGHT_BITS]),
        .tgt_weight   (tgt_rdata_reg[WEIGHT_BITS-1:0]),
        .done         (entry_done),
        .entry_err    (entry_err),
        .entry_metric (entry_metric)
    );

    always_comb
    begin
        state_next       = state_reg;
        dim_cfg_next     = dim_cfg_reg;
        cnt_cfg_next     = cnt_cfg_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        rd_addr_next     = rd_addr_reg;
        issue_ctl_next   = '0;
        cmp_idx_next     = cmp_idx_reg;
        min_metric_next  = min_metric_reg;
        best_err_next    = best_err_reg;
        best_idx_next    = best_idx_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VECTOR_DIM:  dim_cfg_next = cfg_data[VDIM_BITS-1:0];
                REG_ENTRY_COUNT: cnt_cfg_next = cfg_data[ECNT_BITS-1:0];
                default:         ;
            endcase
        end

        if (entry_done)
        begin
            cmp_idx_next = cmp_idx_reg + CNT_W'(1);
        end
        if (take)
        begin
            min_metric_next = entry_metric;
            best_err_next   = EXT_W'(entry_err);
            best_idx_next   = INDEX_BITS'(cmp_idx_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_data.cmd == CMD_SEARCH))
                begin
                    i_next       = '0;
                    j_next       = '0;
                    rd_addr_next = '0;
                    cmp_idx_next = '0;
                    if (cnt_eff == '0)
                    begin
                        best_idx_next = '0;
                        best_err_next = EXT_W'(ERR_MAX);
                        state_next    = ST_RESULT;
                    end
                    else if (dim_eff == '0)
                    begin
                        best_idx_next = '0;
                        best_err_next = '0;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                issue_ctl_next.valid = 1'b1;
                issue_ctl_next.first = (i_reg == '0);
                issue_ctl_next.last  = last_dim;
                rd_addr_next         = rd_addr_reg + AW'(1);
                if (last_dim)
                begin
                    i_next = '0;
                    j_next = j_reg + CNT_W'(1);
                    if (last_entry)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    i_next = i_reg + DIW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (entry_done && last_cmp)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.best_index = best_idx_reg;
                    out_data_next.min_error  = err_sat;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dim_cfg_reg     <= VECTOR_DIM_RESET;
            cnt_cfg_reg     <= ENTRY_COUNT_RESET;
            i_reg           <= '0;
            j_reg           <= '0;
            rd_addr_reg     <= '0;
            issue_ctl_reg   <= '0;
            cmp_idx_reg     <= '0;
            min_metric_reg  <= '0;
            best_err_reg    <= '0;
            best_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            dim_cfg_reg     <= dim_cfg_next;
            cnt_cfg_reg     <= cnt_cfg_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            rd_addr_reg     <= rd_addr_next;
            issue_ctl_reg   <= issue_ctl_next;
            cmp_idx_reg     <= cmp_idx_next;
            min_metric_reg  <= min_metric_next;
            best_err_reg    <= best_err_next;
            best_idx_reg    <= best_idx_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A completed entry only appears while a search is in flight, and never past the last.
    `ASSERT_IMPLIES(a_done_in_search, entry_done,
        ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)) && (cmp_idx_reg < cnt_eff),
        "entry completion outside an active search")
    // Codebook reads stay inside the searched region of the store.
    `ASSERT_IMPLIES(a_read_in_range, state_reg == ST_SCAN,
        (XW'(rd_addr_reg) < XW'(STORE_DEPTH)) && (j_reg < cnt_eff),
        "codebook read beyond the searched entries")
    // A new result word is only produced from the result state.
    `ASSERT_ALWAYS(a_result_source,
        !$rose(out_valid_reg) || ($past(state_reg) == ST_RESULT),
        "result word raised outside the result state")

endmodule

/* hw/rtl/mwvq_dist.sv */
module mwvq_dist #(
    parameter int DIM_MAX = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  mwvq_pkg::elem_ctl_t                           ctl,
    input  logic [mwvq_pkg::SAMPLE_BITS-1:0]              cb_word,
    input  logic [mwvq_pkg::SAMPLE_BITS-1:0]              tgt_value,
    input  logic [mwvq_pkg::WEIGHT_BITS-1:0]              tgt_weight,
    output logic                                          done,
    output logic [mwvq_pkg::SQ_W+$clog2(DIM_MAX)-1:0]     entry_err,
    output logic [mwvq_pkg::WSQ_W+$clog2(DIM_MAX)-1:0]    entry_metric
);
    import mwvq_pkg::*;

    localparam int ERR_W = SQ_W + $clog2(DIM_MAX);
    localparam int MET_W = WSQ_W + $clog2(DIM_MAX);

    elem_ctl_t ctl_a_reg, ctl_b_reg, ctl_c_reg;
    logic      done_reg;

    logic [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]   mag;
    logic [SAMPLE_BITS-1:0] ad_next, ad_reg;
    logic [WEIGHT_BITS-1:0] w_a_reg, w_b_reg;
    logic [SQ_W-1:0]        sq_next, sq_reg, sq_c_reg;
    logic [WSQ_W-1:0]       wsq_next, wsq_reg;
    logic [ERR_W-1:0]       err_acc_next, err_acc_reg;
    logic [MET_W-1:0]       met_acc_next, met_acc_reg;

    // Absent target elements contribute a zero difference.
    assign diff    = {cb_word[SAMPLE_BITS-1], cb_word} - {tgt_value[SAMPLE_BITS-1], tgt_value};
    assign mag     = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
    assign ad_next = (tgt_value != '0) ? mag[SAMPLE_BITS-1:0] : '0;

    assign sq_next  = SQ_W'(ad_reg) * SQ_W'(ad_reg);
    assign wsq_next = WSQ_W'(w_b_reg) * WSQ_W'(sq_reg);

    assign err_acc_next = ctl_c_reg.first ? ERR_W'(sq_c_reg) : err_acc_reg + ERR_W'(sq_c_reg);
    assign met_acc_next = ctl_c_reg.first ? MET_W'(wsq_reg) : met_acc_reg + MET_W'(wsq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctl_a_reg <= ctl;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
            done_reg  <= ctl_c_reg.valid && ctl_c_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        ad_reg   <= ad_next;
        w_a_reg  <= tgt_weight;
        sq_reg   <= sq_next;
        w_b_reg  <= w_a_reg;
        wsq_reg  <= wsq_next;
        sq_c_reg <= sq_reg;
        if (ctl_c_reg.valid)
        begin
            err_acc_reg <= err_acc_next;
            met_acc_reg <= met_acc_next;
        end
    end

    assign done         = done_reg;
    assign entry_err    = err_acc_reg;
    assign entry_metric = met_acc_reg;

endmodule
